// ===== rtl/core/srfp_pkg.sv =====
// shared types, microcode table and register indexes for the speed ramp profiler
package srfp_pkg;

    typedef struct packed {
        logic [15:0] time_step;
        logic        on_curve;
        logic        leader_present;
        logic [31:0] leader_position;
        logic [15:0] leader_speed;
    } tick_item_t;

    typedef struct packed {
        logic        mode_changed;
        logic [1:0]  motion_mode_out;
        logic [15:0] speed_out;
        logic [31:0] position_out;
    } result_item_t;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned STEP_W    = 2;
    localparam int unsigned STEPS     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRAIGHT_LIMIT = 2'd0,
        REG_CURVE_LIMIT    = 2'd1,
        REG_RAMP_RATE      = 2'd2,
        REG_VEHICLE_LEN    = 2'd3
    } cfg_reg_t;

    // motion mode as reported in a result transaction
    typedef enum logic [1:0] {
        MOTION_IDLE   = 2'd0,
        MOTION_ACCEL  = 2'd1,
        MOTION_CRUISE = 2'd2,
        MOTION_DECEL  = 2'd3
    } motion_code_t;

    typedef enum logic [1:0] {
        MUL_NONE  = 2'd0,
        MUL_RAMP  = 2'd1,
        MUL_SPEED = 2'd2
    } mul_op_t;

    typedef enum logic [1:0] {
        COND_NONE        = 2'd0,
        COND_NO_ITEM     = 2'd1,
        COND_OUT_BLOCKED = 2'd2
    } jump_cond_t;

    // datapath part of a control word
    typedef struct packed {
        logic    take;
        mul_op_t mul_op;
        logic    upd_motion;
        logic    finish;
    } ctrl_t;

    // status fed back to the sequencer for conditional jumps
    typedef struct packed {
        logic item_avail;
        logic out_blocked;
    } stat_t;

    typedef struct packed {
        ctrl_t             ctrl;
        jump_cond_t        cond;
        logic [STEP_W-1:0] next;
    } ucode_t;

    // program: take tick, pick target and multiply ramp by time step, ramp speed, position multiply, write back
    localparam ucode_t UCODE [STEPS] = '{
        '{ctrl: '{take: 1'b1, mul_op: MUL_RAMP, upd_motion: 1'b0, finish: 1'b0},
          cond: COND_NO_ITEM, next: 2'd1},
        '{ctrl: '{take: 1'b0, mul_op: MUL_NONE, upd_motion: 1'b1, finish: 1'b0},
          cond: COND_NONE, next: 2'd2},
        '{ctrl: '{take: 1'b0, mul_op: MUL_SPEED, upd_motion: 1'b0, finish: 1'b0},
          cond: COND_NONE, next: 2'd3},
        '{ctrl: '{take: 1'b0, mul_op: MUL_NONE, upd_motion: 1'b0, finish: 1'b1},
          cond: COND_OUT_BLOCKED, next: 2'd0}
    };

endpackage

// ===== rtl/core/speed_ramp_follow_profiler_core.sv =====
// top level: trapezoidal speed profiler with curve and leader speed caps
// a tick runs a 4-step microcode program over one shared 32x16 multiplier
// the result is registered in the finish step; the next tick waits until that step
// a finished result may wait in the output register while the next tick is taken
// reset clears speed, position and mode to idle and loads the default limits
// config writes are always ready
module speed_ramp_follow_profiler_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick_valid,
    output logic                           tick_stall,
    input  srfp_pkg::tick_item_t           tick,
    output logic                           result_valid,
    input  logic                           result_stall,
    output srfp_pkg::result_item_t         result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [srfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import srfp_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    assign tick_stall = !ctrl.take;
    assign cfg_ready  = 1'b1;

    srfp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    srfp_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .tick_valid   (tick_valid),
        .tick         (tick),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/core/srfp_seq.sv =====
// microcode sequencer: step counter, control rom and conditional hold
module srfp_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  srfp_pkg::stat_t stat,
    output srfp_pkg::ctrl_t ctrl
);
    import srfp_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              stay;

    assign word = UCODE[step_reg];

    always_comb
    begin
        case (word.cond)
            COND_NONE:        stay = 1'b0;
            COND_NO_ITEM:     stay = !stat.item_avail;
            COND_OUT_BLOCKED: stay = stat.out_blocked;
            default:          stay = 1'b0;
        endcase
    end

    // a held step issues no datapath action
    assign ctrl      = stay ? '0 : word.ctrl;
    assign step_next = stay ? step_reg : word.next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/core/srfp_dp.sv =====
// datapath: config registers, shared multiplier, speed/position state, result register
module srfp_dp #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srfp_pkg::ctrl_t                 ctrl,
    output srfp_pkg::stat_t                 stat,
    input  logic                            tick_valid,
    input  srfp_pkg::tick_item_t            tick,
    input  logic                            cfg_we,
    input  logic [srfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                     cfg_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output srfp_pkg::result_item_t          result
);
    import srfp_pkg::*;

    localparam int unsigned SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int unsigned SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_ACCEL  = 4'b0010,
        MODE_CRUISE = 4'b0100,
        MODE_DECEL  = 4'b1000
    } mode_t;

    logic [15:0] straight_reg, curve_reg, ramp_reg;
    logic [14:0] vlen_reg;

    logic [15:0] dt_reg;
    logic [15:0] target_reg, target_next;
    logic [47:0] prod_reg;
    logic [31:0] speed_reg, speed_next;
    logic [47:0] pos_reg;
    mode_t       mode_reg, mode_next;
    logic        changed_reg, changed_next;

    logic        result_valid_reg;
    result_item_t result_reg;

    logic        take;
    logic [47:0] far_pos;
    logic [48:0] near_pos;
    logic        close;
    logic [15:0] tgt_a;

    logic [47:0] tgt_wide;
    logic [31:0] tgt_acc;
    logic [47:0] inc;
    logic [47:0] acc_sum;
    logic [31:0] acc_sat;
    logic [47:0] dec_lim;

    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] step_val;
    logic [48:0] pos_sum;
    logic [47:0] pos_next;
    logic [31:0] speed_sh;
    motion_code_t mode_code;

    assign take = ctrl.take & tick_valid;

    // target choice: curve cap, then leader cap when inside twice the vehicle length
    always_comb
    begin
        far_pos  = {tick.leader_position, 16'b0};
        near_pos = {1'b0, pos_reg} + 49'({vlen_reg, 17'b0});
        close    = {1'b0, far_pos} < near_pos;
        tgt_a    = straight_reg;
        if (tick.on_curve && (curve_reg < tgt_a))
        begin
            tgt_a = curve_reg;
        end
        target_next = tgt_a;
        if (tick.leader_present && close && (tick.leader_speed < tgt_a))
        begin
            target_next = tick.leader_speed;
        end
    end

    // motion update
    always_comb
    begin
        tgt_wide = 48'(target_reg) << FRAC_BITS;
        tgt_acc  = (|tgt_wide[47:32]) ? '1 : tgt_wide[31:0];
        inc      = ({16'b0, prod_reg[31:0]} << SH_L) >> SH_R;
        acc_sum  = {16'b0, speed_reg} + inc;
        acc_sat  = (|acc_sum[47:32]) ? '1 : acc_sum[31:0];
        dec_lim  = {16'b0, tgt_acc} + inc;

        speed_next   = speed_reg;
        mode_next    = mode_reg;
        changed_next = 1'b0;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (target_reg != '0)
                begin
                    mode_next    = MODE_ACCEL;
                    changed_next = 1'b1;
                end
            end
            MODE_ACCEL:
            begin
                speed_next = acc_sat;
                if (acc_sat >= tgt_acc)
                begin
                    speed_next   = tgt_acc;
                    mode_next    = MODE_CRUISE;
                    changed_next = 1'b1;
                end
            end
            MODE_CRUISE:
            begin
                if (speed_reg > tgt_acc)
                begin
                    mode_next    = MODE_DECEL;
                    changed_next = 1'b1;
                end
            end
            MODE_DECEL:
            begin
                if ({16'b0, speed_reg} <= dec_lim)
                begin
                    speed_next   = tgt_acc;
                    mode_next    = MODE_CRUISE;
                    changed_next = 1'b1;
                end
                else
                begin
                    speed_next = speed_reg - inc[31:0];
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        case (ctrl.mul_op)
            MUL_RAMP:
            begin
                mul_a = {16'b0, ramp_reg};
                mul_b = tick.time_step;
            end
            MUL_SPEED:
            begin
                mul_a = speed_reg;
                mul_b = dt_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // position integration and result fields
    always_comb
    begin
        step_val = prod_reg >> FRAC_BITS;
        pos_sum  = {1'b0, pos_reg} + {1'b0, step_val};
        pos_next = pos_sum[48] ? '1 : pos_sum[47:0];
        speed_sh = speed_reg >> FRAC_BITS;
        case (mode_reg)
            MODE_IDLE:   mode_code = MOTION_IDLE;
            MODE_ACCEL:  mode_code = MOTION_ACCEL;
            MODE_CRUISE: mode_code = MOTION_CRUISE;
            MODE_DECEL:  mode_code = MOTION_DECEL;
            default:     mode_code = MOTION_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            straight_reg     <= 16'd2000;
            curve_reg        <= 16'd1000;
            ramp_reg         <= 16'd500;
            vlen_reg         <= 15'd1000;
            speed_reg        <= '0;
            pos_reg          <= '0;
            mode_reg         <= MODE_IDLE;
            changed_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_STRAIGHT_LIMIT: straight_reg <= cfg_data;
                    REG_CURVE_LIMIT:    curve_reg    <= cfg_data;
                    REG_RAMP_RATE:      ramp_reg     <= cfg_data;
                    REG_VEHICLE_LEN:    vlen_reg     <= cfg_data[14:0];
                    default:            ;
                endcase
            end
            if (ctrl.upd_motion)
            begin
                speed_reg   <= speed_next;
                mode_reg    <= mode_next;
                changed_reg <= changed_next;
            end
            if (ctrl.finish)
            begin
                pos_reg          <= pos_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dt_reg     <= tick.time_step;
            target_reg <= target_next;
        end
        if (ctrl.mul_op != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctrl.finish)
        begin
            result_reg.mode_changed    <= changed_reg;
            result_reg.motion_mode_out <= mode_code;
            result_reg.speed_out       <= speed_sh[15:0];
            result_reg.position_out    <= pos_next[47:16];
        end
    end

    assign stat.item_avail  = tick_valid;
    assign stat.out_blocked = result_valid_reg & result_stall;
    assign result_valid     = result_valid_reg;
    assign result           = result_reg;

endmodule
